[rtl/core/psa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_pkg
// Shared types and constants for the page span allocator.
// ----------------------------------------------------------------------------
package psa_pkg;

  localparam int SPAN_SLOTS     = 4096;
  localparam int ARENA_PAGES    = 4096;
  localparam int MAX_SPAN_PAGES = 128;
  localparam int PAGE_BITS      = 13;

  localparam int SLOT_W = 12;
  localparam int PAGE_W = 12;
  localparam int LEN_W  = 8;
  localparam int LINK_W = 13;
  localparam int ADDR_W = 25;
  localparam int HEAD_W = 8;

  localparam logic [LINK_W-1:0] NO_SPAN = LINK_W'(SPAN_SLOTS);

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_LOOKUP  = 2'd2;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OOM       = 2'd1;
  localparam logic [1:0] ST_TOO_LARGE = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [LEN_W-1:0]  page_count;
    logic [SLOT_W-1:0] span_handle;
    logic [ADDR_W-1:0] object_address;
  } psa_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] span_id;
    logic [PAGE_W-1:0] first_page;
    logic [LEN_W-1:0]  span_pages;
  } psa_rsp_t;

  // span descriptor, one memory word per slot
  typedef struct packed {
    logic              in_use;
    logic [PAGE_W-1:0] start;
    logic [LEN_W-1:0]  len;
    logic [LINK_W-1:0] next;
    logic [LINK_W-1:0] prev;
  } psa_desc_t;

  function automatic psa_rsp_t ok_rsp(input logic [SLOT_W-1:0] slot,
                                      input logic [PAGE_W-1:0] first,
                                      input logic [LEN_W-1:0] len);
    psa_rsp_t r;
    r.status     = ST_OK;
    r.span_id    = slot;
    r.first_page = first;
    r.span_pages = len;
    return r;
  endfunction

  function automatic psa_rsp_t fail_rsp(input logic [1:0] st);
    psa_rsp_t r;
    r            = '0;
    r.status     = st;
    return r;
  endfunction

endpackage

[rtl/core/psa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_ram
// Simple dual-port synchronous RAM, registered read, write-first forwarding.
// ----------------------------------------------------------------------------
module psa_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    wa,
  input  logic [WIDTH-1:0] wd,
  input  logic [AW-1:0]    ra,
  output logic [WIDTH-1:0] rd
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  always_ff @(posedge clk) begin
    if (we && wa == ra) begin
      rd <= wd;
    end else begin
      rd <= mem[ra];
    end
  end

endmodule

[rtl/core/psa_engine.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_engine
// Sequencer that walks the descriptor, page-owner, slot-stack and list-head
// memories for one allocate, release or lookup item at a time.
// ----------------------------------------------------------------------------
module psa_engine (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  psa_pkg::psa_req_t  req,
  output logic               idle,
  output logic               res_valid,
  input  logic               res_take,
  output psa_pkg::psa_rsp_t  res
);
  import psa_pkg::*;

  typedef enum logic [41:0] {
    S_CLR    = 42'd1 << 0,  S_IDLE   = 42'd1 << 1,  S_FIN    = 42'd1 << 2,
    S_AL_CHK = 42'd1 << 3,  S_AL_EX  = 42'd1 << 4,  S_AL_EX2 = 42'd1 << 5,
    S_AL_SCN = 42'd1 << 6,  S_AL_GRW = 42'd1 << 7,  S_AL_G1  = 42'd1 << 8,
    S_AL_G2  = 42'd1 << 9,  S_SP0    = 42'd1 << 10, S_SP1    = 42'd1 << 11,
    S_SP2    = 42'd1 << 12, S_SP3    = 42'd1 << 13, S_SP4    = 42'd1 << 14,
    S_SP5    = 42'd1 << 15, S_SP6    = 42'd1 << 16, S_RL0    = 42'd1 << 17,
    S_RL1    = 42'd1 << 18, S_BK0    = 42'd1 << 19, S_BK1    = 42'd1 << 20,
    S_BK2    = 42'd1 << 21, S_BK3    = 42'd1 << 22, S_FW0    = 42'd1 << 23,
    S_FW1    = 42'd1 << 24, S_FW2    = 42'd1 << 25, S_FW3    = 42'd1 << 26,
    S_RL_END = 42'd1 << 27, S_RL_E2  = 42'd1 << 28, S_RL_E3  = 42'd1 << 29,
    S_LK0    = 42'd1 << 30, S_LK1    = 42'd1 << 31, S_LK2    = 42'd1 << 32,
    S_ER0    = 42'd1 << 33, S_ER1    = 42'd1 << 34, S_ER2    = 42'd1 << 35,
    S_ER3    = 42'd1 << 36, S_ER4    = 42'd1 << 37, S_PU0    = 42'd1 << 38,
    S_PU1    = 42'd1 << 39, S_PU2    = 42'd1 << 40, S_MK     = 42'd1 << 41
  } state_t;

  localparam logic [LEN_W-1:0]  MAX_LEN   = LEN_W'(MAX_SPAN_PAGES);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(SPAN_SLOTS - 1);
  localparam logic [LINK_W-1:0] ARENA_END = LINK_W'(ARENA_PAGES);
  localparam logic [LINK_W-1:0] FULL_TOP  = LINK_W'(SPAN_SLOTS);

  state_t state, state_next, ret, ret_next;
  logic [LEN_W-1:0]  n, n_next, len_s, len_s_next, arg_len, arg_len_next, cnt, cnt_next;
  logic [LEN_W-1:0]  cur_len, cur_len_next;
  logic [SLOT_W-1:0] h, h_next, s, s_next, old, old_next, o, o_next, lk, lk_next;
  logic [SLOT_W-1:0] arg_slot, arg_slot_next, clr_idx, clr_idx_next;
  logic [PAGE_W-1:0] page, page_next, cur_start, cur_start_next, arg_start, arg_start_next;
  logic [LINK_W-1:0] top, top_next, arena_next, arena_next_next;
  logic              hv, hv_next;
  logic [MAX_SPAN_PAGES:0] nonempty, nonempty_next;
  psa_desc_t         ed, ed_next;
  psa_rsp_t          res_next;

  logic              desc_we, own_we, stk_we, hd_we;
  logic [SLOT_W-1:0] desc_wa, desc_ra, stk_wa, stk_ra, stk_wd, stk_q;
  logic [PAGE_W-1:0] own_wa, own_ra;
  logic [HEAD_W-1:0] hd_wa, hd_ra;
  psa_desc_t         desc_wd, desc_q, dtmp;
  logic [LINK_W-1:0] own_wd, own_q, hd_wd, hd_q, hsel, np, last_pg;
  logic [LEN_W:0]    sum;

  psa_ram #(.WIDTH($bits(psa_desc_t)), .DEPTH(SPAN_SLOTS)) u_desc (
    .clk(clk), .we(desc_we), .wa(desc_wa), .wd(desc_wd), .ra(desc_ra), .rd(desc_q));
  psa_ram #(.WIDTH(LINK_W), .DEPTH(ARENA_PAGES)) u_owner (
    .clk(clk), .we(own_we), .wa(own_wa), .wd(own_wd), .ra(own_ra), .rd(own_q));
  psa_ram #(.WIDTH(SLOT_W), .DEPTH(SPAN_SLOTS)) u_stack (
    .clk(clk), .we(stk_we), .wa(stk_wa), .wd(stk_wd), .ra(stk_ra), .rd(stk_q));
  psa_ram #(.WIDTH(LINK_W), .DEPTH(MAX_SPAN_PAGES + 1)) u_head (
    .clk(clk), .we(hd_we), .wa(hd_wa), .wd(hd_wd), .ra(hd_ra), .rd(hd_q));

  assign idle      = (state == S_IDLE);
  assign res_valid = (state == S_FIN);

  always_comb begin
    state_next = state;   ret_next = ret;       n_next = n;         len_s_next = len_s;
    arg_len_next = arg_len; cnt_next = cnt;     cur_len_next = cur_len;
    h_next = h;           s_next = s;           old_next = old;     o_next = o;
    lk_next = lk;         arg_slot_next = arg_slot; clr_idx_next = clr_idx;
    page_next = page;     cur_start_next = cur_start; arg_start_next = arg_start;
    top_next = top;       arena_next_next = arena_next; hv_next = hv;
    nonempty_next = nonempty; ed_next = ed; res_next = res;
    desc_we = 1'b0; desc_wa = '0; desc_wd = '0; desc_ra = '0;
    own_we = 1'b0;  own_wa = '0;  own_wd = '0;  own_ra = '0;
    stk_we = 1'b0;  stk_wa = '0;  stk_wd = '0;  stk_ra = '0;
    hd_we = 1'b0;   hd_wa = '0;   hd_wd = '0;   hd_ra = '0;
    dtmp = desc_q;
    hsel = hv ? hd_q : NO_SPAN;
    np = {1'b0, cur_start} + LINK_W'(cur_len);
    last_pg = np - LINK_W'(1);
    sum = {1'b0, cur_len} + {1'b0, desc_q.len};

    case (state)
      S_CLR: begin
        desc_we = 1'b1; desc_wa = clr_idx;
        own_we = 1'b1;  own_wa = clr_idx; own_wd = NO_SPAN;
        stk_we = 1'b1;  stk_wa = clr_idx; stk_wd = LAST_SLOT - clr_idx;
        clr_idx_next = clr_idx + SLOT_W'(1);
        if (clr_idx == LAST_SLOT) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          n_next    = req.page_count;
          h_next    = req.span_handle;
          page_next = req.object_address[ADDR_W-1:PAGE_BITS];
          case (req.operation)
            OP_ALLOC:   state_next = S_AL_CHK;
            OP_RELEASE: state_next = S_RL0;
            OP_LOOKUP:  state_next = S_LK0;
            default: begin
              res_next   = fail_rsp(ST_NOT_FOUND);
              state_next = S_FIN;
            end
          endcase
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end

      // ---- allocate ----
      S_AL_CHK: begin
        if (n == '0 || n > MAX_LEN) begin
          res_next = fail_rsp(ST_TOO_LARGE); state_next = S_FIN;
        end else if (nonempty[n]) begin
          hd_ra = n; state_next = S_AL_EX;
        end else begin
          len_s_next = n + LEN_W'(1); state_next = S_AL_SCN;
        end
      end
      S_AL_EX: begin
        s_next = hd_q[SLOT_W-1:0]; arg_slot_next = hd_q[SLOT_W-1:0];
        arg_len_next = n; ret_next = S_AL_EX2; state_next = S_ER0;
      end
      S_AL_EX2: begin
        dtmp = ed; dtmp.in_use = 1'b1;
        desc_we = 1'b1; desc_wa = s; desc_wd = dtmp;
        res_next = ok_rsp(s, ed.start, ed.len);
        arg_slot_next = s; arg_start_next = ed.start; arg_len_next = ed.len;
        cnt_next = '0; ret_next = S_FIN; state_next = S_MK;
      end
      S_AL_SCN: begin
        // one size list a cycle
        if (len_s > MAX_LEN) begin
          state_next = S_AL_GRW;
        end else if (nonempty[len_s]) begin
          if (top == '0) begin
            res_next = fail_rsp(ST_OOM); state_next = S_FIN;
          end else begin
            state_next = S_SP0;
          end
        end else begin
          len_s_next = len_s + LEN_W'(1);
        end
      end
      S_AL_GRW: begin
        if (top < ((n == MAX_LEN) ? LINK_W'(1) : LINK_W'(2)) ||
            ({1'b0, arena_next} + (LINK_W+1)'(MAX_SPAN_PAGES)) > (LINK_W+1)'(ARENA_PAGES))
        begin
          res_next = fail_rsp(ST_OOM); state_next = S_FIN;
        end else begin
          stk_ra = SLOT_W'(top - LINK_W'(1)); top_next = top - LINK_W'(1);
          state_next = S_AL_G1;
        end
      end
      S_AL_G1: begin
        s_next = stk_q;
        arena_next_next = arena_next + LINK_W'(MAX_SPAN_PAGES);
        if (n == MAX_LEN) begin
          dtmp = '0; dtmp.in_use = 1'b1;
          dtmp.start = arena_next[PAGE_W-1:0]; dtmp.len = MAX_LEN;
          desc_we = 1'b1; desc_wa = stk_q; desc_wd = dtmp;
          res_next = ok_rsp(stk_q, arena_next[PAGE_W-1:0], MAX_LEN);
          arg_slot_next = stk_q; arg_start_next = arena_next[PAGE_W-1:0];
          arg_len_next = MAX_LEN; cnt_next = '0; ret_next = S_FIN; state_next = S_MK;
        end else begin
          arg_slot_next = stk_q; arg_start_next = arena_next[PAGE_W-1:0];
          arg_len_next = MAX_LEN; ret_next = S_AL_G2; state_next = S_PU0;
        end
      end
      S_AL_G2: begin
        len_s_next = MAX_LEN; state_next = S_SP0;
      end

      // ---- split the front span of list len_s ----
      S_SP0: begin
        hd_ra = len_s; state_next = S_SP1;
      end
      S_SP1: begin
        old_next = hd_q[SLOT_W-1:0]; arg_slot_next = hd_q[SLOT_W-1:0];
        arg_len_next = len_s; ret_next = S_SP2; state_next = S_ER0;
      end
      S_SP2: begin
        stk_ra = SLOT_W'(top - LINK_W'(1)); top_next = top - LINK_W'(1);
        state_next = S_SP3;
      end
      S_SP3: begin
        s_next = stk_q;
        dtmp = '0; dtmp.in_use = 1'b1; dtmp.start = ed.start; dtmp.len = n;
        desc_we = 1'b1; desc_wa = stk_q; desc_wd = dtmp;
        res_next = ok_rsp(stk_q, ed.start, n);
        cur_start_next = ed.start + PAGE_W'(n);
        cur_len_next = len_s - n;
        state_next = S_SP4;
      end
      S_SP4: begin
        own_we = 1'b1; own_wa = cur_start; own_wd = LINK_W'(old);
        state_next = S_SP5;
      end
      S_SP5: begin
        own_we = (last_pg < ARENA_END); own_wa = last_pg[PAGE_W-1:0];
        own_wd = LINK_W'(old);
        arg_slot_next = old; arg_start_next = cur_start; arg_len_next = cur_len;
        ret_next = S_SP6; state_next = S_PU0;
      end
      S_SP6: begin
        arg_slot_next = s; arg_start_next = res.first_page; arg_len_next = n;
        cnt_next = '0; ret_next = S_FIN; state_next = S_MK;
      end

      // ---- release ----
      S_RL0: begin
        desc_ra = h; state_next = S_RL1;
      end
      S_RL1: begin
        if (!desc_q.in_use || desc_q.len == '0 || desc_q.len > MAX_LEN) begin
          res_next = fail_rsp(ST_NOT_FOUND); state_next = S_FIN;
        end else begin
          cur_start_next = desc_q.start; cur_len_next = desc_q.len;
          state_next = S_BK0;
        end
      end
      S_BK0: begin
        if (cur_start != '0) begin
          own_ra = cur_start - PAGE_W'(1); state_next = S_BK1;
        end else begin
          state_next = S_FW0;
        end
      end
      S_BK1: begin
        o_next = own_q[SLOT_W-1:0];
        if (own_q >= NO_SPAN || own_q[SLOT_W-1:0] == h) begin
          state_next = S_FW0;
        end else begin
          desc_ra = own_q[SLOT_W-1:0]; state_next = S_BK2;
        end
      end
      S_BK2: begin
        if (desc_q.in_use || sum > (LEN_W+1)'(MAX_SPAN_PAGES)) begin
          state_next = S_FW0;
        end else begin
          cur_start_next = desc_q.start; cur_len_next = sum[LEN_W-1:0];
          arg_slot_next = o; arg_len_next = desc_q.len;
          ret_next = S_BK3; state_next = S_ER0;
        end
      end
      S_BK3, S_FW3: begin
        if (top < FULL_TOP) begin
          stk_we = 1'b1; stk_wa = top[SLOT_W-1:0]; stk_wd = o;
          top_next = top + LINK_W'(1);
        end
        state_next = (state == S_BK3) ? S_BK0 : S_FW0;
      end
      S_FW0: begin
        if (np >= ARENA_END) begin
          state_next = S_RL_END;
        end else begin
          own_ra = np[PAGE_W-1:0]; state_next = S_FW1;
        end
      end
      S_FW1: begin
        o_next = own_q[SLOT_W-1:0];
        if (own_q >= NO_SPAN || own_q[SLOT_W-1:0] == h) begin
          state_next = S_RL_END;
        end else begin
          desc_ra = own_q[SLOT_W-1:0]; state_next = S_FW2;
        end
      end
      S_FW2: begin
        if (desc_q.in_use || sum > (LEN_W+1)'(MAX_SPAN_PAGES)) begin
          state_next = S_RL_END;
        end else begin
          cur_len_next = sum[LEN_W-1:0];
          arg_slot_next = o; arg_len_next = desc_q.len;
          ret_next = S_FW3; state_next = S_ER0;
        end
      end
      S_RL_END: begin
        arg_slot_next = h; arg_start_next = cur_start; arg_len_next = cur_len;
        ret_next = S_RL_E2; state_next = S_PU0;
      end
      S_RL_E2: begin
        own_we = 1'b1; own_wa = cur_start; own_wd = LINK_W'(h);
        state_next = S_RL_E3;
      end
      S_RL_E3: begin
        own_we = (last_pg < ARENA_END); own_wa = last_pg[PAGE_W-1:0];
        own_wd = LINK_W'(h);
        res_next = ok_rsp(h, cur_start, cur_len);
        state_next = S_FIN;
      end

      // ---- lookup ----
      S_LK0: begin
        own_ra = page; state_next = S_LK1;
      end
      S_LK1: begin
        o_next = own_q[SLOT_W-1:0];
        if (own_q >= NO_SPAN) begin
          res_next = fail_rsp(ST_NOT_FOUND); state_next = S_FIN;
        end else begin
          desc_ra = own_q[SLOT_W-1:0]; state_next = S_LK2;
        end
      end
      S_LK2: begin
        if (!desc_q.in_use || page < desc_q.start ||
            {1'b0, page} >= ({1'b0, desc_q.start} + LINK_W'(desc_q.len))) begin
          res_next = fail_rsp(ST_NOT_FOUND);
        end else begin
          res_next = ok_rsp(o, desc_q.start, desc_q.len);
        end
        state_next = S_FIN;
      end

      // ---- unlink arg_slot from list arg_len; its descriptor lands in ed ----
      S_ER0: begin
        desc_ra = arg_slot; state_next = S_ER1;
      end
      S_ER1: begin
        ed_next = desc_q;
        if (desc_q.prev < NO_SPAN) begin
          desc_ra = desc_q.prev[SLOT_W-1:0]; state_next = S_ER2;
        end else begin
          hd_we = 1'b1; hd_wa = arg_len; hd_wd = desc_q.next;
          nonempty_next[arg_len] = (desc_q.next < NO_SPAN);
          state_next = S_ER3;
        end
      end
      S_ER2: begin
        dtmp.next = ed.next;
        desc_we = 1'b1; desc_wa = ed.prev[SLOT_W-1:0]; desc_wd = dtmp;
        state_next = S_ER3;
      end
      S_ER3: begin
        if (ed.next < NO_SPAN) begin
          desc_ra = ed.next[SLOT_W-1:0]; state_next = S_ER4;
        end else begin
          state_next = ret;
        end
      end
      S_ER4: begin
        dtmp.prev = ed.prev;
        desc_we = 1'b1; desc_wa = ed.next[SLOT_W-1:0]; desc_wd = dtmp;
        state_next = ret;
      end

      // ---- push arg_slot as a free span at the front of list arg_len ----
      S_PU0: begin
        hv_next = nonempty[arg_len]; hd_ra = arg_len; state_next = S_PU1;
      end
      S_PU1: begin
        dtmp = '0; dtmp.start = arg_start; dtmp.len = arg_len;
        dtmp.next = hsel; dtmp.prev = NO_SPAN;
        desc_we = 1'b1; desc_wa = arg_slot; desc_wd = dtmp;
        hd_we = 1'b1; hd_wa = arg_len; hd_wd = LINK_W'(arg_slot);
        nonempty_next[arg_len] = 1'b1;
        lk_next = hsel[SLOT_W-1:0];
        if (hsel < NO_SPAN) begin
          desc_ra = hsel[SLOT_W-1:0]; state_next = S_PU2;
        end else begin
          state_next = ret;
        end
      end
      S_PU2: begin
        dtmp.prev = LINK_W'(arg_slot);
        desc_we = 1'b1; desc_wa = lk; desc_wd = dtmp;
        state_next = ret;
      end

      // ---- one owner entry per page ----
      S_MK: begin
        if (cnt < arg_len) begin
          np = {1'b0, arg_start} + LINK_W'(cnt);
          own_we = (np < ARENA_END); own_wa = np[PAGE_W-1:0];
          own_wd = LINK_W'(arg_slot);
          cnt_next = cnt + LEN_W'(1);
        end else begin
          state_next = ret;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      ret        <= S_FIN;
      clr_idx    <= '0;
      top        <= FULL_TOP;
      arena_next <= '0;
      nonempty   <= '0;
    end else begin
      state      <= state_next;
      ret        <= ret_next;
      clr_idx    <= clr_idx_next;
      top        <= top_next;
      arena_next <= arena_next_next;
      nonempty   <= nonempty_next;
    end
  end

  always_ff @(posedge clk) begin
    n <= n_next;           len_s <= len_s_next;     arg_len <= arg_len_next;
    cnt <= cnt_next;       cur_len <= cur_len_next; h <= h_next;
    s <= s_next;           old <= old_next;         o <= o_next;
    lk <= lk_next;         arg_slot <= arg_slot_next; page <= page_next;
    cur_start <= cur_start_next; arg_start <= arg_start_next;
    hv <= hv_next;         ed <= ed_next;           res <= res_next;
  end

endmodule

[rtl/core/page_span_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_span_allocator_core
// Page-span allocator with per-length free lists and neighbor coalescing.
// ----------------------------------------------------------------------------
// Request channel req (req_valid / req_stall) carries allocate, release and
// lookup items; response channel rsp (rsp_valid / rsp_stall) returns one
// result item per request, in order.
// One item is worked on at a time; req_stall is high while the sequencer is
// busy. Lookup reads the page owner and then its descriptor; release merges
// free neighbors before and after the span; allocate takes an exact fit, or
// else scans the longer size lists one per cycle and splits the front span
// of the first one that holds a span, growing the arena first when none do.
// The pace is set by the single read port of the descriptor memory and the
// one page-owner write per cycle when marking a span.
// After reset a clearing pass over every slot and page entry initializes the
// slot stack, page-owner map and descriptor in-use bits; req_stall stays
// high meanwhile.
// The result sits in an output register; while rsp_stall holds it, the
// next request is still accepted and processed up to its own result.
// ----------------------------------------------------------------------------
module page_span_allocator_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  psa_pkg::psa_req_t req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output psa_pkg::psa_rsp_t rsp
);
  import psa_pkg::*;

  logic     eng_idle, eng_valid, eng_take;
  psa_rsp_t eng_res;

  assign req_stall = !eng_idle;
  assign eng_take  = !rsp_valid || !rsp_stall;

  psa_engine u_engine (
    .clk      (clk),
    .rst      (rst),
    .start    (req_valid && eng_idle),
    .req      (req),
    .idle     (eng_idle),
    .res_valid(eng_valid),
    .res_take (eng_take),
    .res      (eng_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (eng_take) begin
      rsp_valid <= eng_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (eng_take && eng_valid) begin
      rsp <= eng_res;
    end
  end

endmodule

[bench/psa_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psa_checker
// Watches both channels of the page span allocator, keeps its own copy of the
// free lists, page map and slot stack, predicts each result and compares.
// ----------------------------------------------------------------------------
module psa_checker
  import psa_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  input  logic     req_stall,
  input  psa_req_t req,
  input  logic     rsp_valid,
  input  logic     rsp_stall,
  input  psa_rsp_t rsp,
  output int       errors,
  output int       pending
);

  int unsigned seg_start [SPAN_SLOTS];
  int unsigned seg_len   [SPAN_SLOTS];
  bit          seg_busy  [SPAN_SLOTS];
  int unsigned link_next [SPAN_SLOTS];
  int unsigned link_prev [SPAN_SLOTS];
  int unsigned len_head  [MAX_SPAN_PAGES+1];
  int unsigned owner_of  [ARENA_PAGES];
  int unsigned slot_pool [SPAN_SLOTS];
  int unsigned pool_top;
  int unsigned arena_top;

  psa_rsp_t expected_rsps[$];

  function automatic void clear_state();
    for (int i = 0; i < SPAN_SLOTS; i++) begin
      seg_start[i] = 0; seg_len[i] = 0; seg_busy[i] = 0;
      link_next[i] = 0; link_prev[i] = 0;
      slot_pool[i] = SPAN_SLOTS - 1 - i;
    end
    for (int i = 0; i <= MAX_SPAN_PAGES; i++) len_head[i] = SPAN_SLOTS;
    for (int i = 0; i < ARENA_PAGES; i++) owner_of[i] = SPAN_SLOTS;
    pool_top  = SPAN_SLOTS;
    arena_top = 0;
  endfunction

  function automatic void list_add(int unsigned len, int unsigned s);
    int unsigned h;
    h = len_head[len];
    link_prev[s] = SPAN_SLOTS;
    link_next[s] = h;
    if (h < SPAN_SLOTS) link_prev[h] = s;
    len_head[len] = s;
  endfunction

  function automatic void list_del(int unsigned len, int unsigned s);
    int unsigned p, n;
    p = link_prev[s];
    n = link_next[s];
    if (p < SPAN_SLOTS) link_next[p] = n; else len_head[len] = n;
    if (n < SPAN_SLOTS) link_prev[n] = p;
  endfunction

  function automatic void own(int unsigned page, int unsigned s);
    if (page < ARENA_PAGES) owner_of[page] = s;
  endfunction

  function automatic psa_rsp_t span_rsp(logic [1:0] st, int unsigned s);
    psa_rsp_t r;
    r = '0;
    r.status = st;
    if (st == ST_OK) begin
      r.span_id    = s[SLOT_W-1:0];
      r.first_page = seg_start[s][PAGE_W-1:0];
      r.span_pages = seg_len[s][LEN_W-1:0];
    end
    return r;
  endfunction

  function automatic void claim(int unsigned s);
    seg_busy[s] = 1;
    for (int unsigned i = 0; i < seg_len[s]; i++) own(seg_start[s] + i, s);
  endfunction

  function automatic psa_rsp_t allocate_pages(int unsigned n);
    int unsigned len, s, old;
    if (n == 0 || n > MAX_SPAN_PAGES) return span_rsp(ST_TOO_LARGE, 0);
    if (len_head[n] < SPAN_SLOTS) begin
      s = len_head[n];
      list_del(n, s);
      claim(s);
      return span_rsp(ST_OK, s);
    end
    for (len = n + 1; len <= MAX_SPAN_PAGES; len++)
      if (len_head[len] < SPAN_SLOTS) break;
    if (len > MAX_SPAN_PAGES) begin
      if (pool_top < ((n == MAX_SPAN_PAGES) ? 1 : 2) ||
          arena_top + MAX_SPAN_PAGES > ARENA_PAGES)
        return span_rsp(ST_OOM, 0);
      pool_top--;
      s = slot_pool[pool_top];
      seg_start[s] = arena_top;
      seg_len[s]   = MAX_SPAN_PAGES;
      seg_busy[s]  = 0;
      arena_top += MAX_SPAN_PAGES;
      if (n == MAX_SPAN_PAGES) begin
        claim(s);
        return span_rsp(ST_OK, s);
      end
      list_add(MAX_SPAN_PAGES, s);
      len = MAX_SPAN_PAGES;
    end else if (pool_top == 0) begin
      return span_rsp(ST_OOM, 0);
    end
    // split the front span of the shortest longer list that holds one
    old = len_head[len];
    list_del(len, old);
    pool_top--;
    s = slot_pool[pool_top];
    seg_start[s] = seg_start[old];
    seg_len[s]   = n;
    seg_start[old] += n;
    seg_len[old] = len - n;
    own(seg_start[old], old);
    own(seg_start[old] + seg_len[old] - 1, old);
    list_add(len - n, old);
    claim(s);
    return span_rsp(ST_OK, s);
  endfunction

  function automatic psa_rsp_t release_span(int unsigned h);
    int unsigned o, np;
    if (!seg_busy[h] || seg_len[h] == 0 || seg_len[h] > MAX_SPAN_PAGES)
      return span_rsp(ST_NOT_FOUND, 0);
    while (seg_start[h] > 0) begin
      o = owner_of[seg_start[h] - 1];
      if (o >= SPAN_SLOTS || o == h || seg_busy[o]) break;
      if (seg_len[h] + seg_len[o] > MAX_SPAN_PAGES) break;
      seg_start[h] = seg_start[o];
      seg_len[h] += seg_len[o];
      list_del(seg_len[o], o);
      if (pool_top < SPAN_SLOTS) begin slot_pool[pool_top] = o; pool_top++; end
    end
    forever begin
      np = seg_start[h] + seg_len[h];
      if (np >= ARENA_PAGES) break;
      o = owner_of[np];
      if (o >= SPAN_SLOTS || o == h || seg_busy[o]) break;
      if (seg_len[h] + seg_len[o] > MAX_SPAN_PAGES) break;
      seg_len[h] += seg_len[o];
      list_del(seg_len[o], o);
      if (pool_top < SPAN_SLOTS) begin slot_pool[pool_top] = o; pool_top++; end
    end
    list_add(seg_len[h], h);
    seg_busy[h] = 0;
    own(seg_start[h], h);
    own(seg_start[h] + seg_len[h] - 1, h);
    return span_rsp(ST_OK, h);
  endfunction

  function automatic psa_rsp_t find_owner(logic [ADDR_W-1:0] addr);
    int unsigned page, o;
    page = addr >> PAGE_BITS;
    if (page >= ARENA_PAGES) return span_rsp(ST_NOT_FOUND, 0);
    o = owner_of[page];
    if (o >= SPAN_SLOTS || !seg_busy[o] || page < seg_start[o] ||
        page >= seg_start[o] + seg_len[o])
      return span_rsp(ST_NOT_FOUND, 0);
    return span_rsp(ST_OK, o);
  endfunction

  function automatic psa_rsp_t predict(psa_req_t r);
    case (r.operation)
      OP_ALLOC:   return allocate_pages(r.page_count);
      OP_RELEASE: return release_span(r.span_handle);
      OP_LOOKUP:  return find_owner(r.object_address);
      default:    return span_rsp(ST_NOT_FOUND, 0);
    endcase
  endfunction

  always @(posedge clk) begin
    psa_rsp_t exp_rsp;
    if (rst) begin
      clear_state();
      expected_rsps.delete();
      errors  <= 0;
      pending <= 0;
    end else begin
      if (req_valid && !req_stall) expected_rsps.push_back(predict(req));
      if (rsp_valid && !rsp_stall) begin
        if (expected_rsps.size() == 0) begin
          if (errors < 10) $display("%0t: unexpected result %p", $realtime, rsp);
          errors <= errors + 1;
        end else begin
          exp_rsp = expected_rsps[0];
          expected_rsps.delete(0);
          if (rsp.status !== exp_rsp.status || rsp.span_id !== exp_rsp.span_id ||
              rsp.first_page !== exp_rsp.first_page ||
              rsp.span_pages !== exp_rsp.span_pages) begin
            if (errors < 10)
              $display("%0t: mismatch expected %p actual %p", $realtime, exp_rsp, rsp);
            errors <= errors + 1;
          end
        end
      end
      pending <= expected_rsps.size();
    end
  end

endmodule

[bench/tb_page_span_allocator_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_page_span_allocator_core
// Drives allocate, release, lookup and undefined-operation items with random
// gaps and result stalls; the checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_page_span_allocator_core;
  import psa_pkg::*;

  // the one operation code the block does not define
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic     clk = 0;
  logic     rst = 1;
  logic     req_valid = 0;
  logic     req_stall;
  psa_req_t req = '0;
  logic     rsp_valid;
  logic     rsp_stall = 0;
  psa_rsp_t rsp;
  int       errors;
  int       pending;
  int       stall_left = 0;

  page_span_allocator_core u_top (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
  );

  psa_checker u_checker (
    .clk(clk), .rst(rst), .req_valid(req_valid), .req_stall(req_stall), .req(req),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp),
    .errors(errors), .pending(pending)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 80);
  endfunction

  // result side stalls in bursts, with stretches of none
  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end else begin
      rsp_stall  <= ($urandom_range(0, 2) == 0);
      stall_left <= gap_len();
    end
  end

  task automatic send(logic [1:0] op, int unsigned cnt, int unsigned hdl,
                      int unsigned addr);
    int g;
    g = gap_len();
    if (g > 0) begin
      req_valid <= 0;
      repeat (g) @(posedge clk);
    end
    req.operation      <= op;
    req.page_count     <= cnt[LEN_W-1:0];
    req.span_handle    <= hdl[SLOT_W-1:0];
    req.object_address <= addr[ADDR_W-1:0];
    req_valid          <= 1;
    do @(posedge clk); while (req_stall);
  endtask

  function automatic int unsigned page_addr(int unsigned page);
    return (page << PAGE_BITS) | $urandom_range(0, (1 << PAGE_BITS) - 1);
  endfunction

  initial begin
    int r;
    repeat (8) @(posedge clk);
    rst <= 0;
    // directed: size extremes, every operation, merges, misses
    send(OP_ALLOC, 0, 0, 0);
    send(OP_ALLOC, 129, 0, 0);
    send(OP_ALLOC, 255, 0, 0);
    send(OP_LOOKUP, 1, 0, 0);
    send(OP_RELEASE, 1, 0, 0);
    send(OP_ALLOC, 128, 0, 0);
    send(OP_ALLOC, 1, 0, 0);
    send(OP_ALLOC, 127, 0, 0);
    send(OP_ALLOC, 3, 0, 0);
    send(OP_LOOKUP, 1, 0, page_addr(0));
    send(OP_LOOKUP, 1, 0, page_addr(128));
    send(OP_LOOKUP, 1, 0, 32'h1FF_FFFF);
    send(OP_UNUSED, 255, 4095, 32'h1FF_FFFF);
    send(OP_RELEASE, 1, 4095, 0);
    send(OP_RELEASE, 1, 1, 0);
    send(OP_RELEASE, 1, 1, 0);
    send(OP_RELEASE, 1, 0, 0);
    send(OP_RELEASE, 1, 3, 0);
    send(OP_RELEASE, 1, 2, 0);
    send(OP_LOOKUP, 1, 0, page_addr(130));
    send(OP_ALLOC, 128, 0, 0);
    send(OP_ALLOC, 64, 0, 0);
    for (int i = 0; i < 850; i++) begin
      r = $urandom_range(0, 99);
      if (r < 45) begin
        r = $urandom_range(0, 99);
        send(OP_ALLOC, (r < 60) ? $urandom_range(1, 8) :
                       (r < 95) ? $urandom_range(1, 128) : $urandom_range(0, 255), 0, 0);
      end else if (r < 75) begin
        send(OP_RELEASE, 0, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 4095)
                                                       : $urandom_range(0, 80), 0);
      end else if (r < 95) begin
        send(OP_LOOKUP, 0, 0, ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32'h1FF_FFFF)
                                                         : page_addr($urandom_range(0, 1023)));
      end else begin
        send(OP_UNUSED, $urandom_range(0, 255), $urandom_range(0, 4095),
             $urandom_range(0, 32'h1FF_FFFF));
      end
    end
    req_valid <= 0;
    while (pending != 0) @(posedge clk);
    repeat (400) @(posedge clk);
    if (errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

[files.f]
rtl/core/psa_pkg.sv
rtl/core/psa_ram.sv
rtl/core/psa_engine.sv
rtl/core/page_span_allocator_core.sv
bench/psa_checker.sv
bench/tb_page_span_allocator_core.sv
